// File: rtl/enfc_pkg.sv
// ----------------------------------------------------------------------------
// enfc_pkg: shared types and constants of the nearest-floor elevator controller
// Field widths, result kinds, directions, the input and output beat types and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none
package enfc_pkg;
	localparam int MaxRequests = 16;
	localparam int MaxFloors   = 64;
	localparam int FloorW      = 7;
	localparam int SlotW       = 4;
	localparam int TimeW       = 16;

	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_DROP   = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic             func;
		logic [FloorW-1:0] source_floor;
		logic [FloorW-1:0] dest_floor;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SlotW-1:0]  slot;
		logic [FloorW-1:0] floor;
		logic [1:0]        direction;
		logic [TimeW-1:0]  arrival_time;
		logic              last;
	} out_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_SCAN,
		ST_STATUS
	} state_t;
endpackage
`default_nettype wire

// File: rtl/enfc_cell.sv
// ----------------------------------------------------------------------------
// enfc_cell: one request-table slot of the cell chain
// Holds one passenger entry; entries rotate one place per cycle during a walk.
// ----------------------------------------------------------------------------
`default_nettype none
module enfc_cell #(
	parameter int FW = 6,
	parameter int SW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift,
	input  wire logic          load,
	input  wire logic          in_valid,
	input  wire logic          in_boarded,
	input  wire logic [FW-1:0] in_src,
	input  wire logic [FW-1:0] in_dst,
	input  wire logic [SW-1:0] in_slot,
	output logic               valid_q,
	output logic               boarded_q,
	output logic [FW-1:0]      src_q,
	output logic [FW-1:0]      dst_q,
	output logic [SW-1:0]      slot_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			boarded_q <= 1'b0;
		end else if (shift || load) begin
			valid_q   <= in_valid;
			boarded_q <= in_boarded;
		end
	end

	always_ff @(posedge clk) begin
		if (shift || load) begin
			src_q  <= in_src;
			dst_q  <= in_dst;
			slot_q <= in_slot;
		end
	end
endmodule
`default_nettype wire

// File: rtl/elevator_nearest_floor_controller_top.sv
// ----------------------------------------------------------------------------
// elevator_nearest_floor_controller_top: single-car nearest-floor controller
// Request table as a rotating chain of slot cells, floor marks scanned outward.
// ----------------------------------------------------------------------------
// An add beat puts its one result beat on the ports in the cycle right after
// its accepting edge. A tick beat walks the MaxRequests cells (one per cycle,
// drops emitted as they pass the head), scans distances outward from the car,
// then emits the status beat. With no marked floor the scan runs to the far
// end, so the distance is at most MaxFloors. An add beat leaves busy low; a
// tick beat holds busy high until its status beat.
// Reset clears the table, the floor marks, the step count and puts the car
// at floor 1, stopped, with a floor count of 64. The receiver cannot stall.
`default_nettype none
module elevator_nearest_floor_controller_top #(
	parameter int MAX_REQUESTS = enfc_pkg::MaxRequests,
	parameter int MAX_FLOORS   = enfc_pkg::MaxFloors
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire enfc_pkg::in_beat_t  in_beat,
	output logic                     busy,
	input  wire logic                cfg_we,
	input  wire logic [6:0]          cfg_wdata,
	output logic                     result_strobe,
	output enfc_pkg::out_beat_t      result
);
	import enfc_pkg::*;

	localparam int FW = $clog2(MAX_FLOORS);
	localparam int SW = SlotW;
	localparam int CW = $clog2(MAX_REQUESTS + 1);

	// Chain wiring: cell k feeds cell k-1; the head (cell 0) wraps to the tail.
	logic          c_valid   [MAX_REQUESTS];
	logic          c_boarded [MAX_REQUESTS];
	logic [FW-1:0] c_src     [MAX_REQUESTS];
	logic [FW-1:0] c_dst     [MAX_REQUESTS];
	logic [SW-1:0] c_slot    [MAX_REQUESTS];
	logic          n_valid   [MAX_REQUESTS];
	logic          n_boarded [MAX_REQUESTS];
	logic [FW-1:0] n_src     [MAX_REQUESTS];
	logic [FW-1:0] n_dst     [MAX_REQUESTS];
	logic [SW-1:0] n_slot    [MAX_REQUESTS];
	logic          c_load    [MAX_REQUESTS];

	state_t         state_q, state_d;
	logic [6:0]     floor_count_q;
	logic [MAX_FLOORS-1:0] marks_q;
	logic [FW-1:0]  car_q;
	logic [1:0]     dir_q;
	logic [TimeW-1:0] step_q;
	logic [CW-1:0]  walk_q;
	logic [FW:0]    dist_q;
	logic           shift;

	// Head cell action during a walk.
	logic head_board, head_drop;
	assign head_board = c_valid[0] && !c_boarded[0] && c_src[0] == car_q;
	assign head_drop  = c_valid[0] &&  c_boarded[0] && c_dst[0] == car_q;
	assign shift = (state_q == ST_WALK);

	// Add request: lowest free slot, found by priority over cell valid bits.
	logic [7:0] limit;
	logic       src_ok, dst_ok, have_free;
	logic [SW-1:0] free_idx;
	logic [6:0] s_in, d_in;
	logic accept_add;
	assign limit = (floor_count_q > 7'(MAX_FLOORS)) ? 8'(MAX_FLOORS) : {1'b0, floor_count_q};
	assign s_in = in_beat.source_floor;
	assign d_in = in_beat.dest_floor;
	assign src_ok = s_in != 7'd0 && {1'b0, s_in} <= limit;
	assign dst_ok = d_in != 7'd0 && {1'b0, d_in} <= limit;
	always_comb begin
		have_free = 1'b0;
		free_idx  = '0;
		for (int k = MAX_REQUESTS - 1; k >= 0; k--) begin
			if (!c_valid[k]) begin
				have_free = 1'b1;
				free_idx  = SW'(k);
			end
		end
	end
	logic go;
	assign go = start && !busy;
	assign accept_add = go && in_beat.func == FUNC_ADD && src_ok && dst_ok && have_free;

	// Slots rotate with their index, so after a full walk each cell is home again.
	for (genvar k = 0; k < MAX_REQUESTS; k++) begin : g_cell
		localparam int Nx = (k + 1) % MAX_REQUESTS;
		always_comb begin
			c_load[k] = accept_add && free_idx == SW'(k);
			if (c_load[k]) begin
				n_valid[k]   = 1'b1;
				n_boarded[k] = 1'b0;
				n_src[k]     = FW'(s_in - 7'd1);
				n_dst[k]     = FW'(d_in - 7'd1);
				n_slot[k]    = SW'(k);
			end else if (k == MAX_REQUESTS - 1) begin
				n_valid[k]   = c_valid[0] && !head_drop;
				n_boarded[k] = (c_boarded[0] || head_board) && !head_drop;
				n_src[k]     = c_src[0];
				n_dst[k]     = c_dst[0];
				n_slot[k]    = c_slot[0];
			end else begin
				n_valid[k]   = c_valid[Nx];
				n_boarded[k] = c_boarded[Nx];
				n_src[k]     = c_src[Nx];
				n_dst[k]     = c_dst[Nx];
				n_slot[k]    = c_slot[Nx];
			end
		end
		enfc_cell #(.FW(FW), .SW(SW)) u_cell (
			.clk, .arst_n, .shift, .load(c_load[k]),
			.in_valid(n_valid[k]), .in_boarded(n_boarded[k]),
			.in_src(n_src[k]), .in_dst(n_dst[k]), .in_slot(n_slot[k]),
			.valid_q(c_valid[k]), .boarded_q(c_boarded[k]),
			.src_q(c_src[k]), .dst_q(c_dst[k]), .slot_q(c_slot[k])
		);
	end

	// Outward scan: at distance d, lower floor checked first for the tie rule.
	logic [FW:0] lo_f, hi_f;
	logic lo_hit, hi_hit, lo_in, hi_in;
	assign lo_in  = dist_q <= {1'b0, car_q};
	assign lo_f   = {1'b0, car_q} - dist_q;
	assign hi_f   = {1'b0, car_q} + dist_q;
	assign hi_in  = hi_f < (FW+1)'(MAX_FLOORS);
	assign lo_hit = lo_in && marks_q[lo_f[FW-1:0]];
	assign hi_hit = hi_in && marks_q[hi_f[FW-1:0]];
	logic scan_done;
	assign scan_done = lo_hit || hi_hit || (!lo_in && !hi_in);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (go && in_beat.func == FUNC_TICK) state_d = ST_WALK;
			ST_WALK:   if (walk_q == CW'(MAX_REQUESTS - 1)) state_d = ST_SCAN;
			ST_SCAN:   if (scan_done) state_d = ST_STATUS;
			ST_STATUS: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	logic [1:0] new_dir;
	always_comb begin
		if (lo_hit && dist_q != '0) new_dir = DIR_DOWN;
		else if (hi_hit && dist_q != '0) new_dir = DIR_UP;
		else new_dir = DIR_STOP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			floor_count_q <= 7'd64;
			marks_q       <= '0;
			car_q         <= '0;
			dir_q         <= DIR_STOP;
			step_q        <= '0;
			walk_q        <= '0;
			dist_q        <= '0;
			result_strobe <= 1'b0;
			result        <= '0;
		end else begin
			state_q       <= state_d;
			result_strobe <= 1'b0;
			result        <= '0;
			if (cfg_we) floor_count_q <= cfg_wdata;
			if (go && in_beat.func == FUNC_ADD) begin
				result_strobe <= 1'b1;
				result.last   <= 1'b1;
				if (accept_add) begin
					result.kind <= KIND_ACCEPT;
					result.slot <= free_idx;
					marks_q[FW'(s_in - 7'd1)] <= 1'b1;
				end else begin
					result.kind <= KIND_REJECT;
				end
			end
			if (go && in_beat.func == FUNC_TICK) walk_q <= '0;
			if (state_q == ST_WALK) begin
				walk_q <= walk_q + CW'(1);
				if (head_board) marks_q[c_dst[0]] <= 1'b1;
				if (head_drop) begin
					result_strobe       <= 1'b1;
					result.kind         <= KIND_DROP;
					result.slot         <= c_slot[0];
					result.floor        <= FloorW'(car_q) + 7'd1;
					result.arrival_time <= step_q;
				end
				if (walk_q == CW'(MAX_REQUESTS - 1)) begin
					marks_q[car_q] <= 1'b0;
					dist_q <= '0;
				end
			end
			if (state_q == ST_SCAN) begin
				dist_q <= dist_q + (FW+1)'(1);
				if (scan_done) begin
					dir_q <= new_dir;
					if (new_dir == DIR_UP) car_q <= car_q + FW'(1);
					else if (new_dir == DIR_DOWN) car_q <= car_q - FW'(1);
				end
			end
			if (state_q == ST_STATUS) begin
				result_strobe    <= 1'b1;
				result.kind      <= KIND_STATUS;
				result.floor     <= FloorW'(car_q) + 7'd1;
				result.direction <= dir_q;
				result.last      <= 1'b1;
				step_q           <= step_q + TimeW'(1);
			end
		end
	end

	// A drop is never reported outside the table walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.kind == KIND_DROP |-> $past(state_q) == ST_WALK)
		else $error("drop outside walk");
	// Status always ends the item and comes from the status state.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.kind == KIND_STATUS |-> result.last && $past(state_q) == ST_STATUS)
		else $error("bad status beat");
	// The car moves only during the scan, at most one floor per tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_SCAN |=> $stable(car_q))
		else $error("car moved outside scan");
endmodule
`default_nettype wire
